### sv/lrfs_pkg.sv
// Package for the LCD rectangle fill byte sequencer.
// Holds the request, response and configuration types, the phase enum and panel constants.
// No dependencies; every other file imports it.
`default_nettype none

package lrfs_pkg;

   // Panel command bytes
   localparam logic [7:0] CMD_COLUMN_WINDOW = 8'h2A;
   localparam logic [7:0] CMD_ROW_WINDOW    = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE  = 8'h2C;

   // Request opcodes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_PULL  = 1'b1;

   // Configuration register widths and reset values
   localparam int unsigned ROW_OFFSET_W  = 8;
   localparam int unsigned LIMIT_W       = 10;
   localparam int unsigned CSR_DATA_W    = 10;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam logic [ROW_OFFSET_W-1:0] ROW_OFFSET_RESET  = 8'd20;
   localparam logic [LIMIT_W-1:0]      LAST_COLUMN_RESET = 10'd239;
   localparam logic [LIMIT_W-1:0]      LAST_ROW_RESET    = 10'd279;

   localparam logic [15:0] COLOR_RESET = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_OFFSET  = 2'd0,
      CSR_LAST_COLUMN = 2'd1,
      CSR_LAST_ROW    = 2'd2
   } csr_reg_type;

   typedef enum logic [3:0] {
      PH_COL_CMD = 4'd0,
      PH_COL_P0  = 4'd1,
      PH_COL_P1  = 4'd2,
      PH_COL_P2  = 4'd3,
      PH_COL_P3  = 4'd4,
      PH_ROW_CMD = 4'd5,
      PH_ROW_P0  = 4'd6,
      PH_ROW_P1  = 4'd7,
      PH_ROW_P2  = 4'd8,
      PH_ROW_P3  = 4'd9,
      PH_MEM_CMD = 4'd10,
      PH_PIXEL   = 4'd11
   } phase_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] x_first;
      logic [15:0] y_first;
      logic [15:0] x_second;
      logic [15:0] y_second;
      logic [15:0] fill_color;
   } req_item_type;

   typedef struct packed {
      logic       valid_res;
      logic [7:0] byte_out;
      logic       is_data;
      logic       end_of_select;
      logic       last;
      logic       busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic [ROW_OFFSET_W-1:0] row_offset;
      logic [LIMIT_W-1:0]      last_column;
      logic [LIMIT_W-1:0]      last_row;
   } cfg_type;

   function automatic logic [15:0] clamp_coord(input logic [15:0] v,
                                               input logic [LIMIT_W-1:0] lim);
      logic [15:0] lim_w;
      lim_w = 16'(lim);
      return (v > lim_w) ? lim_w : v;
   endfunction

endpackage

`default_nettype wire

### sv/lrfs_engine.sv
// Fill sequencer engine: window state, pixel counters and the byte for each step.
// Depends on lrfs_pkg. State advances only when the top level presents a request.
`default_nettype none

module lrfs_engine #(
   parameter int unsigned COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  lrfs_pkg::req_item_type item,
   input  lrfs_pkg::cfg_type      cfg,
   output lrfs_pkg::rsp_item_type result
);
   import lrfs_pkg::*;

   logic                  active_ff, active_in;
   phase_type             phase_ff, phase_in;
   logic [COORD_BITS-1:0] col_lo_ff, col_lo_in, col_hi_ff, col_hi_in;
   logic [COORD_BITS-1:0] row_lo_ff, row_lo_in, row_hi_ff, row_hi_in;
   logic [COORD_BITS-1:0] pixel_in_row_ff, pixel_in_row_in;
   logic [COORD_BITS-1:0] rows_done_ff, rows_done_in;
   logic [15:0]           color_ff, color_in;
   logic                  low_byte_next_ff, low_byte_next_in;

   logic                  do_start, do_pull, in_pixels, fill_end;
   logic [15:0]           x_lo, x_hi, y_lo, y_hi;
   logic [15:0]           col_lo_c, col_hi_c, row_lo_c, row_hi_c;
   logic [COORD_BITS-1:0] width_m1, rows_m1;
   logic [16:0]           row_lo_sum, row_hi_sum;
   logic [15:0]           col_lo_w, col_hi_w;

   assign do_start  = (item.cmd == CMD_START) && !active_ff;
   assign do_pull   = (item.cmd == CMD_PULL) && active_ff;
   assign in_pixels = do_pull && (phase_ff == PH_PIXEL);

   // Put each corner pair in order
   assign x_lo = (item.x_second < item.x_first) ? item.x_second : item.x_first;
   assign x_hi = (item.x_second < item.x_first) ? item.x_first  : item.x_second;
   assign y_lo = (item.y_second < item.y_first) ? item.y_second : item.y_first;
   assign y_hi = (item.y_second < item.y_first) ? item.y_first  : item.y_second;

   assign col_lo_c = clamp_coord(x_lo, cfg.last_column);
   assign col_hi_c = clamp_coord(x_hi, cfg.last_column);
   assign row_lo_c = clamp_coord(y_lo, cfg.last_row);
   assign row_hi_c = clamp_coord(y_hi, cfg.last_row);

   assign width_m1 = col_hi_ff - col_lo_ff;
   assign rows_m1  = row_hi_ff - row_lo_ff;
   assign fill_end = in_pixels && low_byte_next_ff
                     && (pixel_in_row_ff >= width_m1) && (rows_done_ff >= rows_m1);

   assign col_lo_w   = 16'(col_lo_ff);
   assign col_hi_w   = 16'(col_hi_ff);
   assign row_lo_sum = 17'(row_lo_ff) + 17'(cfg.row_offset);
   assign row_hi_sum = 17'(row_hi_ff) + 17'(cfg.row_offset);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (do_start) begin
         phase_in = PH_COL_CMD;
      end else if (do_pull) begin
         case (phase_ff)
            PH_COL_CMD: phase_in = PH_COL_P0;
            PH_COL_P0:  phase_in = PH_COL_P1;
            PH_COL_P1:  phase_in = PH_COL_P2;
            PH_COL_P2:  phase_in = PH_COL_P3;
            PH_COL_P3:  phase_in = PH_ROW_CMD;
            PH_ROW_CMD: phase_in = PH_ROW_P0;
            PH_ROW_P0:  phase_in = PH_ROW_P1;
            PH_ROW_P1:  phase_in = PH_ROW_P2;
            PH_ROW_P2:  phase_in = PH_ROW_P3;
            PH_ROW_P3:  phase_in = PH_MEM_CMD;
            PH_MEM_CMD: phase_in = PH_PIXEL;
            PH_PIXEL:   phase_in = fill_end ? PH_COL_CMD : PH_PIXEL;
            default:    phase_in = PH_COL_CMD;
         endcase
      end
   end

   // Window, colour and pixel counters
   always_comb begin
      active_in        = active_ff;
      col_lo_in        = col_lo_ff;
      col_hi_in        = col_hi_ff;
      row_lo_in        = row_lo_ff;
      row_hi_in        = row_hi_ff;
      color_in         = color_ff;
      pixel_in_row_in  = pixel_in_row_ff;
      rows_done_in     = rows_done_ff;
      low_byte_next_in = low_byte_next_ff;
      if (do_start) begin
         active_in        = 1'b1;
         col_lo_in        = col_lo_c[COORD_BITS-1:0];
         col_hi_in        = col_hi_c[COORD_BITS-1:0];
         row_lo_in        = row_lo_c[COORD_BITS-1:0];
         row_hi_in        = row_hi_c[COORD_BITS-1:0];
         color_in         = item.fill_color;
         pixel_in_row_in  = '0;
         rows_done_in     = '0;
         low_byte_next_in = 1'b0;
      end else if (fill_end) begin
         active_in        = 1'b0;
         col_lo_in        = '0;
         col_hi_in        = '0;
         row_lo_in        = '0;
         row_hi_in        = '0;
         pixel_in_row_in  = '0;
         rows_done_in     = '0;
         low_byte_next_in = 1'b0;
      end else if (in_pixels) begin
         low_byte_next_in = !low_byte_next_ff;
         if (low_byte_next_ff) begin
            if (pixel_in_row_ff >= width_m1) begin
               pixel_in_row_in = '0;
               rows_done_in    = rows_done_ff + COORD_BITS'(1);
            end else begin
               pixel_in_row_in = pixel_in_row_ff + COORD_BITS'(1);
            end
         end
      end
   end

   // Result byte and flags
   always_comb begin
      result          = '0;
      result.busy_res = active_in;
      if (do_pull) begin
         result.valid_res = 1'b1;
         result.is_data   = 1'b1;
         case (phase_ff)
            PH_COL_CMD: begin
               result.byte_out      = CMD_COLUMN_WINDOW;
               result.is_data       = 1'b0;
               result.end_of_select = 1'b1;
            end
            PH_COL_P0: result.byte_out = col_lo_w[15:8];
            PH_COL_P1: result.byte_out = col_lo_w[7:0];
            PH_COL_P2: result.byte_out = col_hi_w[15:8];
            PH_COL_P3: begin
               result.byte_out      = col_hi_w[7:0];
               result.end_of_select = 1'b1;
            end
            PH_ROW_CMD: begin
               result.byte_out      = CMD_ROW_WINDOW;
               result.is_data       = 1'b0;
               result.end_of_select = 1'b1;
            end
            PH_ROW_P0: result.byte_out = row_lo_sum[15:8];
            PH_ROW_P1: result.byte_out = row_lo_sum[7:0];
            PH_ROW_P2: result.byte_out = row_hi_sum[15:8];
            PH_ROW_P3: begin
               result.byte_out      = row_hi_sum[7:0];
               result.end_of_select = 1'b1;
            end
            PH_MEM_CMD: begin
               result.byte_out      = CMD_MEMORY_WRITE;
               result.is_data       = 1'b0;
               result.end_of_select = 1'b1;
            end
            PH_PIXEL: begin
               result.byte_out      = low_byte_next_ff ? color_ff[7:0] : color_ff[15:8];
               result.end_of_select = fill_end;
               result.last          = fill_end;
            end
            default: result.byte_out = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         phase_ff         <= PH_COL_CMD;
         col_lo_ff        <= '0;
         col_hi_ff        <= '0;
         row_lo_ff        <= '0;
         row_hi_ff        <= '0;
         color_ff         <= COLOR_RESET;
         pixel_in_row_ff  <= '0;
         rows_done_ff     <= '0;
         low_byte_next_ff <= 1'b0;
      end else if (step_en) begin
         active_ff        <= active_in;
         phase_ff         <= phase_in;
         col_lo_ff        <= col_lo_in;
         col_hi_ff        <= col_hi_in;
         row_lo_ff        <= row_lo_in;
         row_hi_ff        <= row_hi_in;
         color_ff         <= color_in;
         pixel_in_row_ff  <= pixel_in_row_in;
         rows_done_ff     <= rows_done_in;
         low_byte_next_ff <= low_byte_next_in;
      end
   end

endmodule

`default_nettype wire

### sv/lcd_rect_fill_byte_sequencer_core.sv
// Top level of the LCD rectangle fill byte sequencer.
// Depends on lrfs_pkg and lrfs_engine; holds the request register, response register and CSRs.
//
//   channel   direction  handshake             payload
//   req_*     in         req_valid/req_stall   lrfs_pkg::req_item_type
//   rsp_*     out        rsp_valid/rsp_stall   lrfs_pkg::rsp_item_type
//   csr_*     in         csr_we                csr_index, csr_wdata
//
// One request a cycle while rsp_stall is low; every request gives exactly one response
// (request register, then response register), with the engine step between them.
// Synchronous reset loads the CSR defaults and leaves the sequencer idle.
// rsp_stall holds the response register, and reaches req_stall once the request
// register is full as well.
`default_nettype none

module lcd_rect_fill_byte_sequencer_core #(
   parameter int unsigned COORD_BITS = 10
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  lrfs_pkg::req_item_type                    req_payload,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output lrfs_pkg::rsp_item_type                    rsp_payload,
   input  logic                                      csr_we,
   input  logic [lrfs_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [lrfs_pkg::CSR_DATA_W-1:0]           csr_wdata
);
   import lrfs_pkg::*;

   logic         req_valid_ff;
   req_item_type req_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;
   cfg_type      cfg_ff;
   rsp_item_type step_result;
   logic         advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_offset  <= ROW_OFFSET_RESET;
         cfg_ff.last_column <= LAST_COLUMN_RESET;
         cfg_ff.last_row    <= LAST_ROW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_OFFSET:  cfg_ff.row_offset  <= csr_wdata[ROW_OFFSET_W-1:0];
            CSR_LAST_COLUMN: cfg_ff.last_column <= csr_wdata[LIMIT_W-1:0];
            CSR_LAST_ROW:    cfg_ff.last_row    <= csr_wdata[LIMIT_W-1:0];
            default:         cfg_ff             <= cfg_ff;  // drop writes past the map
         endcase
      end
   end

   lrfs_engine #(
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (req_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

endmodule

`default_nettype wire

### sv/lrfs_port_checker.sv
// Port-level checks for the LCD rectangle fill byte sequencer, bound to its top level.
// Depends on lrfs_pkg; sees only the ports of lcd_rect_fill_byte_sequencer_core.
`default_nettype none

module lrfs_port_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input lrfs_pkg::rsp_item_type rsp_payload
);
   import lrfs_pkg::*;

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // The final pixel byte closes the select and ends the fill
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |->
         rsp_payload.valid_res && rsp_payload.is_data
         && rsp_payload.end_of_select && !rsp_payload.busy_res)
      else $error("last byte without select release or with busy set");

   // A step that sends nothing carries no byte and no flags other than busy_res
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.valid_res |->
         rsp_payload.byte_out == 8'h00 && !rsp_payload.is_data
         && !rsp_payload.end_of_select && !rsp_payload.last)
      else $error("empty response carries a byte or flag");

   // Every command byte is one of the three panel commands, releases select and shows busy
   a_cmd_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.valid_res && !rsp_payload.is_data |->
         rsp_payload.end_of_select && rsp_payload.busy_res
         && (rsp_payload.byte_out == CMD_COLUMN_WINDOW
             || rsp_payload.byte_out == CMD_ROW_WINDOW
             || rsp_payload.byte_out == CMD_MEMORY_WRITE))
      else $error("bad command byte");

endmodule

bind lcd_rect_fill_byte_sequencer_core lrfs_port_checker u_port_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the LCD rectangle fill byte sequencer.
// Programs the window CSRs, drives start and pull requests, predicts every panel byte and checks each response.
// Depends on lrfs_pkg and lcd_rect_fill_byte_sequencer_core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lrfs_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned ITEM_TARGET   = 1150;
   localparam int unsigned PHASE_ITEMS   = 150;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam req_item_type PULL_REQ  = '{CMD_PULL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000};
   localparam req_item_type IDLE_PULL = '{CMD_PULL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF};
   localparam rsp_item_type NO_BYTE      = '0;
   localparam rsp_item_type START_ONLY   = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
   localparam rsp_item_type COL_CMD_BYTE = '{1'b1, CMD_COLUMN_WINDOW, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam rsp_item_type ROW_CMD_BYTE = '{1'b1, CMD_ROW_WINDOW, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam rsp_item_type MEM_CMD_BYTE = '{1'b1, CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0, 1'b1};

   typedef struct packed {
      req_item_type rq;
      logic         literal_rsp;
      rsp_item_type want;
   } directed_row_type;

   // One column by two rows, the first corner past both limits, colour bytes distinct
   localparam int unsigned DIRECTED_ROWS = 19;
   localparam directed_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      '{IDLE_PULL, 1'b1, NO_BYTE},
      '{'{CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'd278, 16'h00FF}, 1'b1, START_ONLY},
      '{'{CMD_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, START_ONLY},
      '{PULL_REQ, 1'b1, COL_CMD_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b1, ROW_CMD_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b1, MEM_CMD_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{PULL_REQ, 1'b0, NO_BYTE},
      '{IDLE_PULL, 1'b1, NO_BYTE}
   };

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_we;
   req_item_type req_payload;
   rsp_item_type rsp_payload;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Sequencer model state
   cfg_type    window;
   logic       filling;
   phase_type  seq_phase;
   logic [9:0] col_lo, col_hi, row_lo, row_hi, pixel_in_row, rows_done;
   logic [15:0] held_color;
   logic       low_byte_next;

   rsp_item_type panel_byte_queue [$];
   int unsigned error_count = 0, bytes_checked = 0, accepted_items = 0, effective_items = 0;
   int unsigned fills_started = 0, settings_applied = 0, quiet_left = 0, cycle_count = 0;

   lcd_rect_fill_byte_sequencer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [9:0] clamp_to_limit(input logic [15:0] v, input logic [9:0] lim);
      return (v > {6'b0, lim}) ? lim : v[9:0];
   endfunction

   function automatic void end_fill();
      filling       = 1'b0;
      seq_phase     = PH_COL_CMD;
      col_lo        = '0;
      col_hi        = '0;
      row_lo        = '0;
      row_hi        = '0;
      pixel_in_row  = '0;
      rows_done     = '0;
      low_byte_next = 1'b0;
   endfunction

   // Advance the model by one request and return the byte it should produce
   function automatic rsp_item_type sequence_panel_byte(input req_item_type rq);
      rsp_item_type r;
      logic [15:0] xa, xb, ya, yb, word;
      logic [9:0]  width_m1, height_m1;
      logic        high_half;
      r = '0;
      if (rq.cmd == CMD_START) begin
         if (!filling) begin
            xa = (rq.x_second < rq.x_first) ? rq.x_second : rq.x_first;
            xb = (rq.x_second < rq.x_first) ? rq.x_first : rq.x_second;
            ya = (rq.y_second < rq.y_first) ? rq.y_second : rq.y_first;
            yb = (rq.y_second < rq.y_first) ? rq.y_first : rq.y_second;
            col_lo        = clamp_to_limit(xa, window.last_column);
            col_hi        = clamp_to_limit(xb, window.last_column);
            row_lo        = clamp_to_limit(ya, window.last_row);
            row_hi        = clamp_to_limit(yb, window.last_row);
            held_color    = rq.fill_color;
            seq_phase     = PH_COL_CMD;
            pixel_in_row  = '0;
            rows_done     = '0;
            low_byte_next = 1'b0;
            filling       = 1'b1;
         end
      end else if (filling) begin
         r.valid_res = 1'b1;
         r.is_data   = 1'b1;
         case (seq_phase)
            PH_COL_CMD, PH_ROW_CMD, PH_MEM_CMD: begin
               r.is_data       = 1'b0;
               r.end_of_select = 1'b1;
               r.byte_out      = (seq_phase == PH_COL_CMD) ? CMD_COLUMN_WINDOW :
                                 (seq_phase == PH_ROW_CMD) ? CMD_ROW_WINDOW : CMD_MEMORY_WRITE;
               seq_phase       = phase_type'(seq_phase + 1);
            end
            PH_PIXEL: begin
               if (!low_byte_next) begin
                  r.byte_out    = held_color[15:8];
                  low_byte_next = 1'b1;
               end else begin
                  r.byte_out    = held_color[7:0];
                  low_byte_next = 1'b0;
                  width_m1      = col_hi - col_lo;
                  height_m1     = row_hi - row_lo;
                  if (pixel_in_row >= width_m1) begin
                     pixel_in_row = '0;
                     if (rows_done >= height_m1) begin
                        r.last          = 1'b1;
                        r.end_of_select = 1'b1;
                        end_fill();
                     end else begin
                        rows_done = rows_done + 10'd1;
                     end
                  end else begin
                     pixel_in_row = pixel_in_row + 10'd1;
                  end
               end
            end
            default: begin
               // coordinate bytes: low corner then high corner, each high byte first
               if (seq_phase < PH_ROW_CMD)
                  word = (seq_phase < PH_COL_P2) ? 16'(col_lo) : 16'(col_hi);
               else
                  word = ((seq_phase < PH_ROW_P2) ? 16'(row_lo) : 16'(row_hi))
                         + 16'(window.row_offset);
               high_half = (seq_phase == PH_COL_P0) || (seq_phase == PH_COL_P2) ||
                           (seq_phase == PH_ROW_P0) || (seq_phase == PH_ROW_P2);
               r.byte_out      = high_half ? word[15:8] : word[7:0];
               r.end_of_select = (seq_phase == PH_COL_P3) || (seq_phase == PH_ROW_P3);
               seq_phase       = phase_type'(seq_phase + 1);
            end
         endcase
      end
      r.busy_res = filling;
      return r;
   endfunction

   task automatic push_request(input req_item_type rq, input logic literal_rsp,
                               input rsp_item_type want);
      rsp_item_type predicted;
      int unsigned  gap;
      req_payload <= rq;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      accepted_items++;
      // a start counts when idle, a pull when a fill is running; the rest is ignored
      if ((rq.cmd == CMD_PULL) == filling) begin
         effective_items++;
         if (rq.cmd == CMD_START) fills_started++;
      end
      predicted = sequence_panel_byte(rq);
      panel_byte_queue.push_back(literal_rsp ? want : predicted);
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(0, 49) == 0) begin
         quiet_left = $urandom_range(20, 80);
         gap = 0;
      end else begin
         gap = gap_length();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until the pipeline has emptied
   task automatic settle();
      req_valid <= 1'b0;
      while (panel_byte_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_window(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROW_OFFSET;
      csr_wdata <= {2'($urandom_range(0, 3)), c.row_offset};
      @(posedge clock);
      csr_index <= CSR_LAST_COLUMN;
      csr_wdata <= c.last_column;
      @(posedge clock);
      csr_index <= CSR_LAST_ROW;
      csr_wdata <= c.last_row;
      @(posedge clock);
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      window = c;
      settings_applied++;
   endtask

   // Mostly small spans starting within or near the limit; tiny windows also get fully random corners
   task automatic pick_corners(input logic [9:0] lim, output logic [15:0] first,
                               output logic [15:0] second);
      int unsigned r, lo, hi, span;
      r = $urandom_range(0, 99);
      if (lim < 8 && r < 20) begin
         lo = $urandom_range(0, 65535);
         hi = $urandom_range(0, 65535);
      end else begin
         if (r < 55)      lo = $urandom_range(0, lim);
         else if (r < 75) lo = (lim < 2) ? $urandom_range(0, 4) : lim - 2 + $urandom_range(0, 4);
         else if (r < 90) lo = $urandom_range(0, 65535);
         else             lo = 65535 - $urandom_range(0, 3);
         r = $urandom_range(0, 99);
         span = (r < 70) ? $urandom_range(0, 2) :
                (r < 96) ? $urandom_range(3, 7) : $urandom_range(8, 24);
         hi = (lo + span > 65535) ? 65535 : lo + span;
      end
      if ($urandom_range(0, 1)) begin
         first  = lo[15:0];
         second = hi[15:0];
      end else begin
         first  = hi[15:0];
         second = lo[15:0];
      end
   endtask

   initial begin : rsp_pacer
      int unsigned hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = ($urandom_range(0, 99) < 8) ? $urandom_range(50, 200) : $urandom_range(1, 6);
         repeat (hold) @(posedge clock);
         hold = gap_length();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : byte_checker
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (panel_byte_queue.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_payload);
            error_count++;
         end else begin
            want = panel_byte_queue.pop_front();
            compare_field("valid_res", want.valid_res, rsp_payload.valid_res);
            compare_field("byte_out", want.byte_out, rsp_payload.byte_out);
            compare_field("is_data", want.is_data, rsp_payload.is_data);
            compare_field("end_of_select", want.end_of_select, rsp_payload.end_of_select);
            compare_field("last", want.last, rsp_payload.last);
            compare_field("busy_res", want.busy_res, rsp_payload.busy_res);
            bytes_checked++;
         end
      end
   end

   initial begin : stimulus
      int unsigned  phase, phase_end;
      cfg_type      setting;
      req_item_type rq;
      logic [15:0]  first, second;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_ROW_OFFSET;
      csr_wdata   <= '0;
      window      = '{ROW_OFFSET_RESET, LAST_COLUMN_RESET, LAST_ROW_RESET};
      end_fill();
      held_color  = COLOR_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         push_request(DIRECTED_PLAN[i].rq, DIRECTED_PLAN[i].literal_rsp, DIRECTED_PLAN[i].want);

      phase = 0;
      while (accepted_items < ITEM_TARGET) begin
         settle();
         case (phase)
            0:       setting = '{8'd0, 10'd0, 10'd0};
            1:       setting = '{8'd255, 10'd1023, 10'd1023};
            2:       setting = '{ROW_OFFSET_RESET, LAST_COLUMN_RESET, LAST_ROW_RESET};
            3:       setting = '{8'd255, 10'd0, 10'd1023};
            4:       setting = '{8'd0, 10'd1023, 10'd0};
            5:       setting = '{8'd3, 10'd5, 10'd7};
            default: setting = '{8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                                 10'($urandom_range(0, 1023))};
         endcase
         program_window(setting);
         phase_end = effective_items + PHASE_ITEMS;
         while (effective_items < phase_end && accepted_items < ITEM_TARGET) begin
            rq = '{1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom)};
            if (filling) begin
               // the odd start while busy must be refused
               rq.cmd = ($urandom_range(0, 99) < 4) ? CMD_START : CMD_PULL;
            end else if ($urandom_range(0, 99) < 8) begin
               rq.cmd = CMD_PULL;
            end else begin
               rq.cmd = CMD_START;
               pick_corners(window.last_column, first, second);
               rq.x_first  = first;
               rq.x_second = second;
               pick_corners(window.last_row, first, second);
               rq.y_first  = first;
               rq.y_second = second;
            end
            push_request(rq, 1'b0, NO_BYTE);
         end
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d panel bytes for %0d requests (%0d that did work).",
               bytes_checked, accepted_items, effective_items);
      $display("Covered %0d fills under %0d window settings.", fills_started, settings_applied);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### lcd_rect_fill_byte_sequencer_core.f
sv/lrfs_pkg.sv
sv/lrfs_engine.sv
sv/lcd_rect_fill_byte_sequencer_core.sv
sv/lrfs_port_checker.sv
tb/sv/tb.sv
